>>> design/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// Shared codes and fixed widths for the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  // fixed field widths of the words on the ports
  localparam int PRICE_W    = 7;
  localparam int AMOUNT_W   = 32;
  localparam int OUT_SIZE_W = 31;

  // action codes
  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  // side codes
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // leaf group width of the best level search tree
  localparam int FIND_GRP   = 8;
  localparam int FIND_GRP_W = 3;

endpackage

>>> design/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// Bid and ask level size tables with top of book on every update word.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | action, side, price, amount
//  out     | out_valid / out_stall | level_size, has_bid, bid_price, bid_size,
//          |                       | has_ask, ask_price, ask_size
//
//  One word per cycle while no stalled result is held; each taken word gives one result.
//  The pipeline is: table read, update and write back, leaf search over the
//  occupancy flags, root search and best level read, result register.
//  Reset clears the occupancy flags at once; the size tables are not cleared.
//  A stalled result freezes the whole pipeline, and in_stall follows it.
// ----------------------------------------------------------------------------
module price_level_order_book
  import plob_pkg::*;
#(
  parameter int PRICE_LEVELS = 128,
  parameter int SIZE_BITS    = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic                       side,
  input  logic [PRICE_W-1:0]         price,
  input  logic signed [AMOUNT_W-1:0] amount,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [OUT_SIZE_W-1:0]      level_size,
  output logic                       has_bid,
  output logic [PRICE_W-1:0]         bid_price,
  output logic [OUT_SIZE_W-1:0]      bid_size,
  output logic                       has_ask,
  output logic [PRICE_W-1:0]         ask_price,
  output logic [OUT_SIZE_W-1:0]      ask_size
);

  localparam int IDX_W = $clog2(PRICE_LEVELS);

  logic                 adv;
  logic                 accept;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_range;

  // stage 1: registered word
  logic                       s1_valid;
  logic                       s1_action;
  logic                       s1_side;
  logic                       s1_in_range;
  logic [IDX_W-1:0]           s1_idx;
  logic signed [AMOUNT_W-1:0] s1_amount;
  logic                       s1_wr;
  logic [SIZE_BITS-1:0]       old_raw;
  logic [SIZE_BITS-1:0]       old_size;
  logic [SIZE_BITS-1:0]       upd_size;
  logic [SIZE_BITS-1:0]       s1_level;
  logic                       occ_cur;

  // last write, for the read that raced it
  logic                 fw_en;
  logic                 fw_side;
  logic [IDX_W-1:0]     fw_idx;
  logic [SIZE_BITS-1:0] fw_size;

  // previous size of the last written level, to undo a write that is too new
  logic                 u_en;
  logic                 u_side;
  logic [IDX_W-1:0]     u_idx;
  logic [SIZE_BITS-1:0] u_old;

  logic [PRICE_LEVELS-1:0] bid_occ;
  logic [PRICE_LEVELS-1:0] ask_occ;

  logic [SIZE_BITS-1:0] bid_rd_a;
  logic [SIZE_BITS-1:0] ask_rd_a;
  logic [SIZE_BITS-1:0] bid_rd_b;
  logic [SIZE_BITS-1:0] ask_rd_b;

  // stages 2 to 4
  logic                 s2_valid;
  logic [SIZE_BITS-1:0] s2_level;
  logic                 s3_valid;
  logic [SIZE_BITS-1:0] s3_level;
  logic                 s4_valid;
  logic [SIZE_BITS-1:0] s4_level;

  logic                 bid_found;
  logic [IDX_W-1:0]     bid_idx;
  logic                 ask_found;
  logic [IDX_W-1:0]     ask_idx;
  logic                 bid_undo_next;
  logic                 ask_undo_next;
  logic                 s4_bid_found;
  logic [IDX_W-1:0]     s4_bid_idx;
  logic                 s4_bid_undo;
  logic                 s4_ask_found;
  logic [IDX_W-1:0]     s4_ask_idx;
  logic                 s4_ask_undo;
  logic [SIZE_BITS-1:0] s4_u_old;
  logic [SIZE_BITS-1:0] bid_best_size;
  logic [SIZE_BITS-1:0] ask_best_size;

  // global advance: the whole pipeline moves unless a result is held
  assign adv      = !(s4_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign in_idx   = IDX_W'(price);
  assign in_range = (32'(price) < 32'(PRICE_LEVELS));

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // stage 1 word register
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action   <= action;
      s1_side     <= side;
      s1_in_range <= in_range;
      s1_idx      <= in_idx;
      s1_amount   <= amount;
    end
  end

  // size tables, read at the incoming price and at the best levels
  plob_level_ram #(
    .DEPTH (PRICE_LEVELS),
    .WIDTH (SIZE_BITS)
  ) u_bid_ram (
    .clk     (clk),
    .en      (adv),
    .we      (s1_wr && (s1_side == SIDE_BID)),
    .waddr   (s1_idx),
    .wdata   (upd_size),
    .raddr_a (in_idx),
    .raddr_b (bid_idx),
    .rdata_a (bid_rd_a),
    .rdata_b (bid_rd_b)
  );

  plob_level_ram #(
    .DEPTH (PRICE_LEVELS),
    .WIDTH (SIZE_BITS)
  ) u_ask_ram (
    .clk     (clk),
    .en      (adv),
    .we      (s1_wr && (s1_side == SIDE_ASK)),
    .waddr   (s1_idx),
    .wdata   (upd_size),
    .raddr_a (in_idx),
    .raddr_b (ask_idx),
    .rdata_a (ask_rd_a),
    .rdata_b (ask_rd_b)
  );

  // old size: forward the write that landed with the read, gate by occupancy
  assign s1_wr   = s1_valid && s1_in_range;
  assign occ_cur = (s1_side == SIDE_ASK) ? ask_occ[s1_idx] : bid_occ[s1_idx];
  always_comb begin
    if (fw_en && (fw_side == s1_side) && (fw_idx == s1_idx)) begin
      old_raw = fw_size;
    end else begin
      old_raw = (s1_side == SIDE_ASK) ? ask_rd_a : bid_rd_a;
    end
  end
  assign old_size = occ_cur ? old_raw : '0;

  plob_update #(
    .SIZE_BITS (SIZE_BITS)
  ) u_update (
    .action   (s1_action),
    .amount   (s1_amount),
    .old_size (old_size),
    .upd_size (upd_size)
  );

  assign s1_level = s1_in_range ? upd_size : '0;

  // occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_occ <= '0;
      ask_occ <= '0;
    end else if (adv && s1_wr) begin
      if (s1_side == SIDE_ASK) begin
        ask_occ[s1_idx] <= |upd_size;
      end else begin
        bid_occ[s1_idx] <= |upd_size;
      end
    end
  end

  // write records for forwarding and undo
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_en <= 1'b0;
      u_en  <= 1'b0;
    end else if (adv) begin
      fw_en <= s1_wr;
      u_en  <= s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_side <= s1_side;
      fw_idx  <= s1_idx;
      fw_size <= upd_size;
      u_side  <= s1_side;
      u_idx   <= s1_idx;
      u_old   <= old_size;
    end
  end

  // stage 2 snapshot of the flags goes into the search trees
  plob_best_find #(
    .LEVELS    (PRICE_LEVELS),
    .FIND_HIGH (1'b1)
  ) u_bid_find (
    .clk   (clk),
    .en    (adv),
    .occ   (bid_occ),
    .found (bid_found),
    .idx   (bid_idx)
  );

  plob_best_find #(
    .LEVELS    (PRICE_LEVELS),
    .FIND_HIGH (1'b0)
  ) u_ask_find (
    .clk   (clk),
    .en    (adv),
    .occ   (ask_occ),
    .found (ask_found),
    .idx   (ask_idx)
  );

  // stage 3: the best level read sees one later write, mark it for undo
  assign bid_undo_next = u_en && (u_side == SIDE_BID) && (u_idx == bid_idx);
  assign ask_undo_next = u_en && (u_side == SIDE_ASK) && (u_idx == ask_idx);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_level     <= s1_level;
      s3_level     <= s2_level;
      s4_level     <= s3_level;
      s4_bid_found <= bid_found;
      s4_bid_idx   <= bid_idx;
      s4_bid_undo  <= bid_undo_next;
      s4_ask_found <= ask_found;
      s4_ask_idx   <= ask_idx;
      s4_ask_undo  <= ask_undo_next;
      s4_u_old     <= u_old;
    end
  end

  // stage 4 result
  assign bid_best_size = s4_bid_undo ? s4_u_old : bid_rd_b;
  assign ask_best_size = s4_ask_undo ? s4_u_old : ask_rd_b;

  assign out_valid  = s4_valid;
  assign level_size = OUT_SIZE_W'(s4_level);
  assign has_bid    = s4_bid_found;
  assign bid_price  = s4_bid_found ? PRICE_W'(s4_bid_idx) : '0;
  assign bid_size   = s4_bid_found ? OUT_SIZE_W'(bid_best_size) : '0;
  assign has_ask    = s4_ask_found;
  assign ask_price  = s4_ask_found ? PRICE_W'(s4_ask_idx) : '0;
  assign ask_size   = s4_ask_found ? OUT_SIZE_W'(ask_best_size) : '0;

endmodule

>>> design/plob_level_ram.sv
// ----------------------------------------------------------------------------
// plob_level_ram
// Level size table: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module plob_level_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 31,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read before write, everything held while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/plob_update.sv
// ----------------------------------------------------------------------------
// plob_update
// New level size from the old size and a set or signed delta, saturating.
// ----------------------------------------------------------------------------
module plob_update
  import plob_pkg::*;
#(
  parameter int SIZE_BITS = 31
) (
  input  logic                       action,
  input  logic signed [AMOUNT_W-1:0] amount,
  input  logic [SIZE_BITS-1:0]       old_size,
  output logic [SIZE_BITS-1:0]       upd_size
);

  localparam int SUM_W = ((SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W) + 1;
  localparam logic [SUM_W-1:0] SIZE_MAX =
    {{(SUM_W - SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};

  logic               neg;
  logic [AMOUNT_W:0]  raw_ext;
  logic [AMOUNT_W:0]  mag;
  logic [SUM_W-1:0]   mag_w;
  logic [SUM_W-1:0]   old_w;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   diff;
  logic [SUM_W-1:0]   result;

  // magnitude of the two's complement amount
  assign neg     = amount[AMOUNT_W-1];
  assign raw_ext = {1'b0, amount};
  assign mag     = neg ? ((AMOUNT_W + 1)'(1) << AMOUNT_W) - raw_ext : raw_ext;
  assign mag_w   = SUM_W'(mag);
  assign old_w   = SUM_W'(old_size);
  assign sum     = old_w + mag_w;
  assign diff    = old_w - mag_w;

  // set clamps to the size range, delta adds or removes
  always_comb begin
    if (action == ACT_SET) begin
      if (neg || (mag == '0)) begin
        result = '0;
      end else begin
        result = (mag_w > SIZE_MAX) ? SIZE_MAX : mag_w;
      end
    end else if (neg) begin
      result = (mag_w >= old_w) ? '0 : diff;
    end else begin
      result = (sum > SIZE_MAX) ? SIZE_MAX : sum;
    end
  end

  assign upd_size = SIZE_BITS'(result);

endmodule

>>> design/plob_best_find.sv
// ----------------------------------------------------------------------------
// plob_best_find
// Two level registered search for the highest or lowest set occupancy flag.
// ----------------------------------------------------------------------------
module plob_best_find
  import plob_pkg::*;
#(
  parameter int LEVELS = 128,
  parameter bit FIND_HIGH = 1'b1,
  localparam int IDX_W = $clog2(LEVELS)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [LEVELS-1:0] occ,
  output logic              found,
  output logic [IDX_W-1:0]  idx
);

  localparam int NG  = (LEVELS + FIND_GRP - 1) / FIND_GRP;
  localparam int NGW = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*FIND_GRP-1:0]  occ_pad;
  logic [NG-1:0]           grp_any;
  logic [NG-1:0]           grp_any_next;
  logic [FIND_GRP_W-1:0]   grp_loc      [NG];
  logic [FIND_GRP_W-1:0]   grp_loc_next [NG];
  logic [NGW-1:0]          sel_g;
  logic [FIND_GRP_W-1:0]   sel_loc;
  logic [NGW+FIND_GRP_W-1:0] sel_full;

  assign occ_pad = (NG * FIND_GRP)'(occ);

  // leaf groups: any flag and best position inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_next[g] = |occ_pad[g*FIND_GRP +: FIND_GRP];
      grp_loc_next[g] = '0;
      if (FIND_HIGH) begin
        for (int b = 0; b < FIND_GRP; b++) begin
          if (occ_pad[g*FIND_GRP + b]) grp_loc_next[g] = FIND_GRP_W'(b);
        end
      end else begin
        for (int b = FIND_GRP - 1; b >= 0; b--) begin
          if (occ_pad[g*FIND_GRP + b]) grp_loc_next[g] = FIND_GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_any <= grp_any_next;
      for (int g = 0; g < NG; g++) begin
        grp_loc[g] <= grp_loc_next[g];
      end
    end
  end

  // root: pick the best non-empty group
  always_comb begin
    sel_g   = '0;
    sel_loc = '0;
    if (FIND_HIGH) begin
      for (int g = 0; g < NG; g++) begin
        if (grp_any[g]) begin
          sel_g   = NGW'(g);
          sel_loc = grp_loc[g];
        end
      end
    end else begin
      for (int g = NG - 1; g >= 0; g--) begin
        if (grp_any[g]) begin
          sel_g   = NGW'(g);
          sel_loc = grp_loc[g];
        end
      end
    end
  end

  assign sel_full = {sel_g, sel_loc};
  assign found    = |grp_any;
  assign idx      = IDX_W'(sel_full);

endmodule
